// ===== rtl/core/crc16x_pkg.sv =====
package crc16x_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_TYPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NETWORK_TYPE  = 2'd1;

  localparam logic [7:0] PROTOCOL_TYPE_RST = 8'h02;
  localparam logic [7:0] NETWORK_TYPE_RST  = 8'h01;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  localparam logic [7:0] DELIM_CHAR     = 8'h21;
  localparam logic [7:0] HEX_DIGIT_BASE = 8'd48;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'd55;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       frame_end;
    logic       run_last;
  } out_word_t;

  typedef struct packed {
    logic [7:0] protocol_type;
    logic [7:0] network_type;
  } cfg_regs_t;

  // character slots of a frame, in emission order
  typedef enum logic [3:0] {
    SL_DELIM,
    SL_PT_HI,
    SL_PT_LO,
    SL_NT_HI,
    SL_NT_LO,
    SL_PL_HI,
    SL_PL_LO,
    SL_CL_HI,
    SL_CL_LO,
    SL_CH_HI,
    SL_CH_LO,
    SL_END
  } slot_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    return (nib < 4'd10) ? (wide + HEX_DIGIT_BASE) : (wide + HEX_ALPHA_BASE);
  endfunction

  // CRC-16, poly 0x1021, MSB first, one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0] b);
    logic [15:0] crc;
    logic [15:0] data;
    logic [15:0] mix;
    crc  = crc_in;
    data = {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      mix = crc ^ data;
      crc = {crc[14:0], 1'b0};
      if ((mix & CRC_MSB) != 16'h0000) begin
        crc = crc ^ CRC_POLY;
      end
      data = {data[14:0], 1'b0};
    end
    return crc;
  endfunction

endpackage

// ===== rtl/core/crc16x_cfg.sv =====
module crc16x_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [crc16x_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crc16x_pkg::CFG_DATA_W-1:0] cfg_data,
  output crc16x_pkg::cfg_regs_t            regs
);
  import crc16x_pkg::*;

  cfg_regs_t cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.protocol_type <= PROTOCOL_TYPE_RST;
      cfg_q.network_type  <= NETWORK_TYPE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROTOCOL_TYPE: cfg_q.protocol_type <= cfg_data;
        REG_NETWORK_TYPE:  cfg_q.network_type  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign regs = cfg_q;

endmodule

// ===== rtl/core/crc16x_seq.sv =====
module crc16x_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  crc16x_pkg::cfg_regs_t  regs,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  crc16x_pkg::in_word_t   item,
  input  logic                   out_free,
  output logic                   issue,
  output crc16x_pkg::out_word_t  sym_next
);
  import crc16x_pkg::*;

  logic        cur_valid;
  logic [7:0]  cur_byte;
  logic        cur_last;
  slot_t       slot;
  slot_t       slot_next;
  slot_t       start_slot;
  logic        inside_frame;
  logic [15:0] crc;
  logic [15:0] crc_next;
  logic        finishing;
  logic        take;
  logic        open_after;

  assign issue      = cur_valid && out_free;
  assign finishing  = issue && ((slot == SL_PL_LO && !cur_last) || slot == SL_END);
  assign item_ready = !cur_valid || finishing;
  assign take       = item_valid && item_ready;

  // frame state as it stands after this edge, for a word taken now
  assign open_after = inside_frame && !(finishing && slot == SL_END);
  assign start_slot = open_after ? SL_PL_HI : SL_DELIM;

  always_comb begin
    slot_next = slot_t'(slot + 4'd1);
    crc_next  = crc;
    sym_next  = '0;
    sym_next.run_last = finishing;
    case (slot)
      SL_DELIM: begin
        sym_next.out_char = DELIM_CHAR;
        crc_next = CRC_INIT;
      end
      SL_PT_HI: sym_next.out_char = hex_char(regs.protocol_type[7:4]);
      SL_PT_LO: begin
        sym_next.out_char = hex_char(regs.protocol_type[3:0]);
        crc_next = crc_feed(crc, regs.protocol_type);
      end
      SL_NT_HI: sym_next.out_char = hex_char(regs.network_type[7:4]);
      SL_NT_LO: begin
        sym_next.out_char = hex_char(regs.network_type[3:0]);
        crc_next = crc_feed(crc, regs.network_type);
      end
      SL_PL_HI: sym_next.out_char = hex_char(cur_byte[7:4]);
      SL_PL_LO: begin
        sym_next.out_char = hex_char(cur_byte[3:0]);
        crc_next = crc_feed(crc, cur_byte);
      end
      SL_CL_HI: sym_next.out_char = hex_char(crc[7:4]);
      SL_CL_LO: sym_next.out_char = hex_char(crc[3:0]);
      SL_CH_HI: sym_next.out_char = hex_char(crc[15:12]);
      SL_CH_LO: sym_next.out_char = hex_char(crc[11:8]);
      SL_END: begin
        sym_next.out_char  = DELIM_CHAR;
        sym_next.frame_end = 1'b1;
        crc_next = CRC_INIT;
      end
      default: begin
        sym_next.out_char = DELIM_CHAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid    <= 1'b0;
      inside_frame <= 1'b0;
      crc          <= CRC_INIT;
    end else begin
      if (take) begin
        cur_valid <= 1'b1;
      end else if (finishing) begin
        cur_valid <= 1'b0;
      end
      if (issue) begin
        crc <= crc_next;
        if (slot == SL_DELIM) begin
          inside_frame <= 1'b1;
        end else if (slot == SL_END) begin
          inside_frame <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_byte <= item.payload_byte;
      cur_last <= item.last_byte;
      slot     <= start_slot;
    end else if (issue) begin
      slot <= slot_next;
    end
  end

  a_crc_clear_outside: assert property (@(posedge clk) disable iff (rst)
    !inside_frame |-> crc == CRC_INIT)
    else $error("crc not cleared outside a frame");

  a_delim_only_closed: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && slot == SL_DELIM) |-> !inside_frame)
    else $error("opening delimiter inside an open frame");

  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    (issue && slot == SL_END) |=> !inside_frame)
    else $error("frame still open after closing delimiter");

  a_finish_slot: assert property (@(posedge clk) disable iff (rst)
    finishing |-> ((slot == SL_PL_LO && !cur_last) || slot == SL_END))
    else $error("word finished at a wrong slot");

endmodule

// ===== rtl/core/crc16x_out.sv =====
module crc16x_out (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  issue,
  input  crc16x_pkg::out_word_t sym_next,
  output logic                  out_free,
  output logic                  sym_valid,
  input  logic                  sym_ready,
  output crc16x_pkg::out_word_t sym
);
  import crc16x_pkg::*;

  logic      valid_q;
  out_word_t word_q;

  assign out_free  = !valid_q || sym_ready;
  assign sym_valid = valid_q;
  assign sym       = word_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (out_free) begin
      valid_q <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && out_free) begin
      word_q <= sym_next;
    end
  end

endmodule

// ===== rtl/core/crc16_hex_ascii_frame_encoder.sv =====
// Frame encoder: raw bytes in, ASCII hex frame out.
// item channel: one payload byte per word, last_byte marks the end of a frame.
// sym channel: one ASCII character per word; frame_end flags the closing '!',
// run_last flags the final character caused by an input word.
// A frame reads "!", protocol and network type as hex, payload as hex, then
// the CRC-16 (0x1021, zero preset) low byte then high byte as hex, then "!".
// Config: cfg_we writes cfg_data into register cfg_index (0 protocol type,
// 1 network type); other indexes are ignored. Write only while idle.
// Path: an accepted word is held in the sequencer, which issues its characters
// into the output register that drives sym.
// Throughput: one character per cycle from the output register while sym_ready
// is high; a word inside a frame gives 2 characters, a frame-opening or
// frame-closing word 7, and a single-byte frame 12. The next word is taken in
// the cycle the current one issues its final character.
// Reset: no frame open, CRC zero, types 2 and 1, both channels empty.
// Stall: while sym_ready is low a full output register holds its word, the
// sequencer stops, and item_ready drops once a word is waiting.
module crc16_hex_ascii_frame_encoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [crc16x_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crc16x_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  crc16x_pkg::in_word_t              item,
  output logic                              sym_valid,
  input  logic                              sym_ready,
  output crc16x_pkg::out_word_t             sym
);
  import crc16x_pkg::*;

  cfg_regs_t regs;
  out_word_t sym_next;
  logic      issue;
  logic      out_free;

  crc16x_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  crc16x_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_free   (out_free),
    .issue      (issue),
    .sym_next   (sym_next)
  );

  crc16x_out u_out (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .sym_next  (sym_next),
    .out_free  (out_free),
    .sym_valid (sym_valid),
    .sym_ready (sym_ready),
    .sym       (sym)
  );

endmodule

// ===== tb/sv/frame_char_checker.sv =====
module frame_char_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [crc16x_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crc16x_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                              item_valid,
  input  logic                              item_ready,
  input  crc16x_pkg::in_word_t              item,
  input  logic                              sym_valid,
  input  logic                              sym_ready,
  input  crc16x_pkg::out_word_t             sym,
  output int                                chars_due,
  output int                                mismatch_cnt
);

  crc16x_pkg::out_word_t exp_chars[$];
  logic [7:0]  proto_shadow;
  logic [7:0]  net_shadow;
  logic        frame_open;
  logic [15:0] frame_crc;
  int          n_bad;

  initial begin
    n_bad = 0;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ crc16x_pkg::CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] nib_ascii(input logic [3:0] n);
    logic [7:0] w;
    w = {4'h0, n};
    if (n < 4'd10) begin
      return w + crc16x_pkg::HEX_DIGIT_BASE;
    end
    return w + crc16x_pkg::HEX_ALPHA_BASE;
  endfunction

  task automatic push_char(input logic [7:0] ch, input logic fe, input logic rl);
    crc16x_pkg::out_word_t w;
    w.out_char  = ch;
    w.frame_end = fe;
    w.run_last  = rl;
    exp_chars.push_back(w);
  endtask

  task automatic push_hex(input logic [7:0] b, input logic rl);
    push_char(nib_ascii(b[7:4]), 1'b0, 1'b0);
    push_char(nib_ascii(b[3:0]), 1'b0, rl);
  endtask

  task automatic predict_word(input crc16x_pkg::in_word_t w);
    if (!frame_open) begin
      frame_crc = crc16x_pkg::CRC_INIT;
      push_char(crc16x_pkg::DELIM_CHAR, 1'b0, 1'b0);
      push_hex(proto_shadow, 1'b0);
      frame_crc = crc16_step(frame_crc, proto_shadow);
      push_hex(net_shadow, 1'b0);
      frame_crc = crc16_step(frame_crc, net_shadow);
      frame_open = 1'b1;
    end
    push_hex(w.payload_byte, !w.last_byte);
    frame_crc = crc16_step(frame_crc, w.payload_byte);
    if (w.last_byte) begin
      push_hex(frame_crc[7:0], 1'b0);
      push_hex(frame_crc[15:8], 1'b0);
      push_char(crc16x_pkg::DELIM_CHAR, 1'b1, 1'b1);
      frame_open = 1'b0;
      frame_crc  = crc16x_pkg::CRC_INIT;
    end
  endtask

  always @(posedge clk) begin
    crc16x_pkg::out_word_t want;
    if (rst) begin
      exp_chars.delete();
      proto_shadow = crc16x_pkg::PROTOCOL_TYPE_RST;
      net_shadow   = crc16x_pkg::NETWORK_TYPE_RST;
      frame_open   = 1'b0;
      frame_crc    = crc16x_pkg::CRC_INIT;
    end else begin
      if (sym_valid && sym_ready) begin
        if (exp_chars.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("unexpected word: char %h end %b last %b",
                     sym.out_char, sym.frame_end, sym.run_last);
          end
        end else begin
          want = exp_chars.pop_front();
          if (sym !== want) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("mismatch: expected char %h end %b last %b, got char %h end %b last %b",
                       want.out_char, want.frame_end, want.run_last,
                       sym.out_char, sym.frame_end, sym.run_last);
            end
          end
        end
      end
      if (item_valid && item_ready) begin
        predict_word(item);
      end
      if (cfg_we) begin
        case (cfg_index)
          crc16x_pkg::REG_PROTOCOL_TYPE: begin
            proto_shadow = cfg_data;
          end
          crc16x_pkg::REG_NETWORK_TYPE: begin
            net_shadow = cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
    chars_due    <= exp_chars.size();
    mismatch_cnt <= n_bad;
  end

endmodule

// ===== tb/sv/crc16_hex_ascii_frame_encoder_tb.sv =====
module crc16_hex_ascii_frame_encoder_tb;

  import crc16x_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_WORDS = 350;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  item_valid = 1'b0;
  in_word_t              item       = '0;
  logic                  sym_ready  = 1'b0;
  logic                  item_ready;
  logic                  sym_valid;
  out_word_t             sym;

  int chars_due;
  int mismatch_cnt;
  int src_idle_pct  = 8;
  int sink_idle_pct = 60;
  int hold_seq      = 0;
  int cycle_cnt     = 0;

  crc16_hex_ascii_frame_encoder dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .sym_valid  (sym_valid),
    .sym_ready  (sym_ready),
    .sym        (sym)
  );

  frame_char_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .sym_valid    (sym_valid),
    .sym_ready    (sym_ready),
    .sym          (sym),
    .chars_due    (chars_due),
    .mismatch_cnt (mismatch_cnt)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("crc16_hex_ascii_frame_encoder_tb: errors");
    $finish;
  end

  // sink side; a bump of hold_seq requests one long hold-off
  initial begin
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        sym_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      sym_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic offer_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid        <= 1'b1;
    item.payload_byte <= b;
    item.last_byte    <= last;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic wait_chars_out();
    item_valid <= 1'b0;
    do @(posedge clk); while (chars_due != 0);
  endtask

  task automatic write_type_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_type();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) begin
      // occasional type write while a frame is open
      if (i > 0 && $urandom_range(15) == 0) begin
        wait_chars_out();
        write_type_reg(2'($urandom_range(3)), pick_type());
      end
      offer_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  initial begin
    int  sent;
    int  len;
    bit  held;
    held = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: one-byte frames, all hex digits, type extremes
    offer_byte(8'h00, 1'b1);
    offer_byte(8'hFF, 1'b1);
    offer_byte(8'h01, 1'b0);
    offer_byte(8'h23, 1'b0);
    offer_byte(8'h45, 1'b0);
    offer_byte(8'h67, 1'b0);
    offer_byte(8'h89, 1'b0);
    offer_byte(8'hAB, 1'b0);
    offer_byte(8'hCD, 1'b0);
    offer_byte(8'hEF, 1'b1);
    wait_chars_out();
    write_type_reg(REG_PROTOCOL_TYPE, 8'h00);
    write_type_reg(REG_NETWORK_TYPE, 8'hFF);
    offer_byte(8'h80, 1'b1);
    wait_chars_out();
    write_type_reg(REG_PROTOCOL_TYPE, 8'hFF);
    write_type_reg(REG_NETWORK_TYPE, 8'h00);
    offer_byte(8'h7F, 1'b0);
    offer_byte(8'h00, 1'b1);
    // type write mid-frame applies from the next frame
    offer_byte(8'h11, 1'b0);
    wait_chars_out();
    write_type_reg(REG_PROTOCOL_TYPE, 8'h3C);
    write_type_reg(REG_NETWORK_TYPE, 8'hC3);
    offer_byte(8'h22, 1'b1);
    offer_byte(8'h33, 1'b1);
    // unused indexes are ignored
    wait_chars_out();
    write_type_reg(REG_UNUSED_2, 8'hAA);
    write_type_reg(REG_UNUSED_3, 8'h55);
    offer_byte(8'h44, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      wait_chars_out();
      case (ph)
        0: begin
          src_idle_pct  = 8;
          sink_idle_pct <= 60;
        end
        1: begin
          src_idle_pct  = 60;
          sink_idle_pct <= 8;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct <= 0;
        end
      endcase
      sent = 0;
      while (sent < RANDOM_WORDS / 3) begin
        if ($urandom_range(7) == 0) begin
          wait_chars_out();
          write_type_reg(2'($urandom_range(3)), pick_type());
        end
        if (!held && sent > 40) begin
          held = 1'b1;
          hold_seq <= hold_seq + 1;
          len = 16;
        end else if ($urandom_range(9) == 0) begin
          len = $urandom_range(12, 24);
        end else begin
          len = $urandom_range(1, 6);
        end
        send_frame(len);
        sent += len;
      end
    end

    wait_chars_out();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && chars_due == 0) begin
      $display("crc16_hex_ascii_frame_encoder_tb: clean");
    end else begin
      $display("crc16_hex_ascii_frame_encoder_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/crc16x_pkg.sv
rtl/core/crc16x_cfg.sv
rtl/core/crc16x_seq.sv
rtl/core/crc16x_out.sv
rtl/core/crc16_hex_ascii_frame_encoder.sv
tb/sv/frame_char_checker.sv
tb/sv/crc16_hex_ascii_frame_encoder_tb.sv
